[design/bsg_pkg.sv]
package bsg_pkg;

   localparam int CW       = 32;
   localparam int RW       = CW - 1;
   localparam int AW       = CW + 1;
   localparam int DIST_W   = AW + 1;
   localparam int EW       = DIST_W + 1;
   localparam int PW       = AW + EW;
   localparam int SQR_W    = DIST_W + 2;
   localparam int SUM_W    = EW + 2;
   localparam int SQ_STEPS = PW / 2;
   localparam int DIV_STEPS = EW;
   localparam int CNT_W    = 6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEED,
      ST_SQ,
      ST_SQRT_INIT,
      ST_SQRT,
      ST_ECALC,
      ST_ZERO,
      ST_AE_MUL,
      ST_DIV_INIT,
      ST_DIV,
      ST_CUPD,
      ST_RUPD,
      ST_FINISH,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic       load;
      logic       seed;
      logic       mul_en;
      logic       mul_sq;
      logic       acc_en;
      logic [1:0] idx;
      logic       sqrt_init;
      logic       sqrt_step;
      logic       ecalc;
      logic       zero;
      logic       div_init;
      logic       div_step;
      logic       cupd;
      logic       rupd;
      logic       finish;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic grows;
      logic dist_zero;
   } status_type;

endpackage

[design/bsg_ctrl.sv]
module bsg_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_first_of_pass,
   input  logic                rsp_free,
   input  bsg_pkg::status_type status,
   output bsg_pkg::cmd_type    cmd,
   output logic                busy
);

   bsg_pkg::state_type            state_ff, state_in;
   logic [bsg_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [1:0]                    idx_ff, idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bsg_pkg::ST_IDLE;
         cnt_ff   <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         idx_ff   <= idx_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      cmd.idx  = idx_ff;
      busy     = (state_ff != bsg_pkg::ST_IDLE);
      case (state_ff)
         bsg_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               idx_in   = '0;
               state_in = req_first_of_pass ? bsg_pkg::ST_SEED : bsg_pkg::ST_SQ;
            end
         end
         bsg_pkg::ST_SEED: begin
            cmd.seed = 1'b1;
            state_in = bsg_pkg::ST_FINISH;
         end
         bsg_pkg::ST_SQ: begin
            cmd.mul_en = (cnt_ff < bsg_pkg::CNT_W'(3));
            cmd.mul_sq = 1'b1;
            cmd.idx    = cnt_ff[1:0];
            cmd.acc_en = (cnt_ff != '0);
            if (cnt_ff == bsg_pkg::CNT_W'(3)) begin
               cnt_in   = '0;
               state_in = bsg_pkg::ST_SQRT_INIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         bsg_pkg::ST_SQRT_INIT: begin
            cmd.sqrt_init = 1'b1;
            cnt_in        = '0;
            state_in      = bsg_pkg::ST_SQRT;
         end
         bsg_pkg::ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (cnt_ff == bsg_pkg::CNT_W'(bsg_pkg::SQ_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = bsg_pkg::ST_ECALC;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         bsg_pkg::ST_ECALC: begin
            cmd.ecalc = 1'b1;
            if (!status.grows) begin
               state_in = bsg_pkg::ST_FINISH;
            end else if (status.dist_zero) begin
               state_in = bsg_pkg::ST_ZERO;
            end else begin
               idx_in   = '0;
               state_in = bsg_pkg::ST_AE_MUL;
            end
         end
         bsg_pkg::ST_ZERO: begin
            cmd.zero = 1'b1;
            state_in = bsg_pkg::ST_FINISH;
         end
         bsg_pkg::ST_AE_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = bsg_pkg::ST_DIV_INIT;
         end
         bsg_pkg::ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            cnt_in       = '0;
            state_in     = bsg_pkg::ST_DIV;
         end
         bsg_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == bsg_pkg::CNT_W'(bsg_pkg::DIV_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = bsg_pkg::ST_CUPD;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         bsg_pkg::ST_CUPD: begin
            cmd.cupd = 1'b1;
            if (idx_ff == 2'd2) begin
               state_in = bsg_pkg::ST_RUPD;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = bsg_pkg::ST_AE_MUL;
            end
         end
         bsg_pkg::ST_RUPD: begin
            cmd.rupd = 1'b1;
            state_in = bsg_pkg::ST_FINISH;
         end
         bsg_pkg::ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = bsg_pkg::ST_OUT;
         end
         bsg_pkg::ST_OUT: begin
            if (rsp_free) begin
               cmd.out_load = 1'b1;
               state_in     = bsg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bsg_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[design/bsg_dp.sv]
module bsg_dp (
   input  logic                         clock,
   input  bsg_pkg::cmd_type             cmd,
   output bsg_pkg::status_type          status,
   input  logic signed [bsg_pkg::CW-1:0] req_center_x,
   input  logic signed [bsg_pkg::CW-1:0] req_center_y,
   input  logic signed [bsg_pkg::CW-1:0] req_center_z,
   input  logic [bsg_pkg::RW-1:0]       req_radius,
   input  logic                         req_last_of_pass,
   input  logic                         req_start_set,
   output logic signed [bsg_pkg::CW-1:0] rsp_pass_center_x,
   output logic signed [bsg_pkg::CW-1:0] rsp_pass_center_y,
   output logic signed [bsg_pkg::CW-1:0] rsp_pass_center_z,
   output logic [bsg_pkg::RW-1:0]       rsp_pass_radius,
   output logic signed [bsg_pkg::CW-1:0] rsp_best_center_x,
   output logic signed [bsg_pkg::CW-1:0] rsp_best_center_y,
   output logic signed [bsg_pkg::CW-1:0] rsp_best_center_z,
   output logic [bsg_pkg::RW-1:0]       rsp_best_radius,
   output logic                         rsp_best_valid,
   output logic                         rsp_grew,
   input  logic                         reset
);

   localparam int CW     = bsg_pkg::CW;
   localparam int RW     = bsg_pkg::RW;
   localparam int AW     = bsg_pkg::AW;
   localparam int DIST_W = bsg_pkg::DIST_W;
   localparam int EW     = bsg_pkg::EW;
   localparam int PW     = bsg_pkg::PW;
   localparam int SQR_W  = bsg_pkg::SQR_W;
   localparam int SUM_W  = bsg_pkg::SUM_W;

   logic [CW-1:0]     s_ff [3];
   logic [CW-1:0]     pc_ff [3];
   logic [CW-1:0]     bc_ff [3];
   logic [AW-1:0]     a_ff [3];
   logic [2:0]        neg_ff;
   logic [RW-1:0]     r_ff;
   logic [RW-1:0]     prad_ff;
   logic [CW-1:0]     brad_ff;
   logic              bval_ff;
   logic              last_ff;
   logic              grew_ff;
   logic [PW-1:0]     prod_ff;
   logic [PW-1:0]     acc_ff;
   logic [PW-1:0]     snum_ff;
   logic [SQR_W-1:0]  srem_ff;
   logic [DIST_W-1:0] sres_ff;
   logic [EW-1:0]     e_ff;
   logic [EW-1:0]     drem_ff;
   logic [EW-1:0]     dq_ff;

   logic [CW-1:0]     req_c [3];
   logic [AW-1:0]     dv [3];
   logic [AW-1:0]     mul_a;
   logic [EW-1:0]     mul_b;
   logic [SQR_W+1:0]  st;
   logic [SQR_W+1:0]  strial;
   logic [EW:0]       dt;
   logic [EW:0]       den;
   logic [EW:0]       reach;
   logic signed [SUM_W-1:0] csum;
   logic signed [SUM_W-1:0] cmax;
   logic signed [SUM_W-1:0] cmin;
   logic [EW:0]       nrad;

   assign req_c[0] = req_center_x;
   assign req_c[1] = req_center_y;
   assign req_c[2] = req_center_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dv[i] = {req_c[i][CW-1], req_c[i]} - {pc_ff[i][CW-1], pc_ff[i]};
      end
      mul_a  = a_ff[cmd.idx];
      mul_b  = cmd.mul_sq ? EW'(a_ff[cmd.idx]) : e_ff;
      st     = {srem_ff, snum_ff[PW-1 -: 2]};
      strial = (SQR_W+2)'({sres_ff, 2'b01});
      den    = (EW+1)'({sres_ff, 1'b0});
      dt     = {drem_ff, dq_ff[EW-1]};
      reach  = (EW+1)'(sres_ff) + (EW+1)'(r_ff);
      status.grows     = reach > (EW+1)'(prad_ff);
      status.dist_zero = (sres_ff == '0);
      cmax = SUM_W'({1'b0, {(CW-1){1'b1}}});
      cmin = ~cmax;
      if (neg_ff[cmd.idx]) begin
         csum = SUM_W'(signed'(pc_ff[cmd.idx])) - signed'(SUM_W'(dq_ff));
      end else begin
         csum = SUM_W'(signed'(pc_ff[cmd.idx])) + signed'(SUM_W'(dq_ff));
      end
      nrad = (EW+1)'(prad_ff) + (EW+1)'(e_ff[EW-1:1]) + (EW+1)'(e_ff[0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            pc_ff[i] <= '0;
            bc_ff[i] <= '0;
         end
         prad_ff <= '0;
         brad_ff <= '1;
         bval_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            for (int i = 0; i < 3; i++) begin
               s_ff[i]   <= req_c[i];
               neg_ff[i] <= dv[i][AW-1];
               a_ff[i]   <= dv[i][AW-1] ? (~dv[i] + 1'b1) : dv[i];
            end
            r_ff    <= req_radius;
            last_ff <= req_last_of_pass;
            grew_ff <= 1'b0;
            acc_ff  <= '0;
            if (req_start_set) begin
               for (int i = 0; i < 3; i++) begin
                  bc_ff[i] <= '0;
               end
               brad_ff <= '1;
               bval_ff <= 1'b0;
            end
         end
         if (cmd.seed) begin
            for (int i = 0; i < 3; i++) begin
               pc_ff[i] <= s_ff[i];
            end
            prad_ff <= r_ff;
         end
         if (cmd.mul_en) begin
            prod_ff <= PW'(mul_a) * PW'(mul_b);
         end
         if (cmd.acc_en) begin
            acc_ff <= acc_ff + prod_ff;
         end
         if (cmd.sqrt_init) begin
            snum_ff <= acc_ff;
            srem_ff <= '0;
            sres_ff <= '0;
         end
         if (cmd.sqrt_step) begin
            snum_ff <= {snum_ff[PW-3:0], 2'b00};
            if (st >= strial) begin
               srem_ff <= SQR_W'(st - strial);
               sres_ff <= {sres_ff[DIST_W-2:0], 1'b1};
            end else begin
               srem_ff <= SQR_W'(st);
               sres_ff <= {sres_ff[DIST_W-2:0], 1'b0};
            end
         end
         if (cmd.ecalc) begin
            grew_ff <= status.grows;
            e_ff    <= EW'(reach - (EW+1)'(prad_ff));
         end
         if (cmd.zero) begin
            prad_ff <= r_ff;
         end
         if (cmd.div_init) begin
            drem_ff <= EW'(prod_ff[PW-1:EW]);
            dq_ff   <= prod_ff[EW-1:0];
         end
         if (cmd.div_step) begin
            if (dt >= den) begin
               drem_ff <= EW'(dt - den);
               dq_ff   <= {dq_ff[EW-2:0], 1'b1};
            end else begin
               drem_ff <= EW'(dt);
               dq_ff   <= {dq_ff[EW-2:0], 1'b0};
            end
         end
         if (cmd.cupd) begin
            if (csum > cmax) begin
               pc_ff[cmd.idx] <= CW'(cmax);
            end else if (csum < cmin) begin
               pc_ff[cmd.idx] <= CW'(cmin);
            end else begin
               pc_ff[cmd.idx] <= CW'(csum);
            end
         end
         if (cmd.rupd) begin
            prad_ff <= (nrad > (EW+1)'({RW{1'b1}})) ? {RW{1'b1}} : RW'(nrad);
         end
         if (cmd.finish && last_ff && (CW'(prad_ff) < brad_ff)) begin
            for (int i = 0; i < 3; i++) begin
               bc_ff[i] <= pc_ff[i];
            end
            brad_ff <= CW'(prad_ff);
            bval_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_pass_center_x <= pc_ff[0];
         rsp_pass_center_y <= pc_ff[1];
         rsp_pass_center_z <= pc_ff[2];
         rsp_pass_radius   <= prad_ff;
         rsp_best_center_x <= bc_ff[0];
         rsp_best_center_y <= bc_ff[1];
         rsp_best_center_z <= bc_ff[2];
         rsp_best_radius   <= brad_ff[RW-1:0];
         rsp_best_valid    <= bval_ff;
         rsp_grew          <= grew_ff;
      end
   end

endmodule

[design/bounding_sphere_grow.sv]
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_stall  sphere center, radius, pass flags
// rsp      out        rsp_valid / rsp_stall  pass sphere, best sphere, status
//
// A word is taken only in idle; req_stall stays high until its result is in the output register.
// A growing word takes longest; enclosed, zero-distance and seeding words skip the divisions,
// and a seeding word also skips the bit-serial square root. That root and the three restoring
// divisions make up most of a growing word's time; one multiplier forms all products.
// Reset is synchronous and needs no clearing pass.
// A finished word waits in the output register while the next word is taken.
module bounding_sphere_grow (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [bsg_pkg::CW-1:0] req_center_x,
   input  logic signed [bsg_pkg::CW-1:0] req_center_y,
   input  logic signed [bsg_pkg::CW-1:0] req_center_z,
   input  logic [bsg_pkg::RW-1:0]        req_radius,
   input  logic                          req_first_of_pass,
   input  logic                          req_last_of_pass,
   input  logic                          req_start_set,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [bsg_pkg::CW-1:0] rsp_pass_center_x,
   output logic signed [bsg_pkg::CW-1:0] rsp_pass_center_y,
   output logic signed [bsg_pkg::CW-1:0] rsp_pass_center_z,
   output logic [bsg_pkg::RW-1:0]        rsp_pass_radius,
   output logic signed [bsg_pkg::CW-1:0] rsp_best_center_x,
   output logic signed [bsg_pkg::CW-1:0] rsp_best_center_y,
   output logic signed [bsg_pkg::CW-1:0] rsp_best_center_z,
   output logic [bsg_pkg::RW-1:0]        rsp_best_radius,
   output logic                          rsp_best_valid,
   output logic                          rsp_grew
);

   bsg_pkg::cmd_type    cmd;
   bsg_pkg::status_type status;
   logic                busy;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_free;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = busy;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   bsg_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_first_of_pass (req_first_of_pass),
      .rsp_free          (rsp_free),
      .status            (status),
      .cmd               (cmd),
      .busy              (busy)
   );

   bsg_dp u_dp (
      .clock             (clock),
      .cmd               (cmd),
      .status            (status),
      .req_center_x      (req_center_x),
      .req_center_y      (req_center_y),
      .req_center_z      (req_center_z),
      .req_radius        (req_radius),
      .req_last_of_pass  (req_last_of_pass),
      .req_start_set     (req_start_set),
      .rsp_pass_center_x (rsp_pass_center_x),
      .rsp_pass_center_y (rsp_pass_center_y),
      .rsp_pass_center_z (rsp_pass_center_z),
      .rsp_pass_radius   (rsp_pass_radius),
      .rsp_best_center_x (rsp_best_center_x),
      .rsp_best_center_y (rsp_best_center_y),
      .rsp_best_center_z (rsp_best_center_z),
      .rsp_best_radius   (rsp_best_radius),
      .rsp_best_valid    (rsp_best_valid),
      .rsp_grew          (rsp_grew),
      .reset             (reset)
   );

endmodule

[tb/sv/testbench.sv]
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [bsg_pkg::CW-1:0] cx, cy, cz;
      logic [bsg_pkg::RW-1:0]        rad;
      logic                          first, last, clr;
   } sphere_type;

   typedef struct {
      logic signed [bsg_pkg::CW-1:0] pcx, pcy, pcz;
      logic [bsg_pkg::RW-1:0]        prad;
      logic signed [bsg_pkg::CW-1:0] bcx, bcy, bcz;
      logic [bsg_pkg::RW-1:0]        brad;
      logic                          bvalid, grew;
   } enclosure_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [bsg_pkg::CW-1:0] req_center_x = 0, req_center_y = 0, req_center_z = 0;
   logic [bsg_pkg::RW-1:0] req_radius = 0;
   logic req_first_of_pass = 0, req_last_of_pass = 0, req_start_set = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [bsg_pkg::CW-1:0] rsp_pass_center_x, rsp_pass_center_y, rsp_pass_center_z;
   logic [bsg_pkg::RW-1:0] rsp_pass_radius;
   logic signed [bsg_pkg::CW-1:0] rsp_best_center_x, rsp_best_center_y, rsp_best_center_z;
   logic [bsg_pkg::RW-1:0] rsp_best_radius;
   logic rsp_best_valid, rsp_grew;

   bounding_sphere_grow dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   sphere_type    pending_spheres[$];
   enclosure_type expected_spheres[$];
   int            errors = 0;
   int            accepted = 0;
   int            answered = 0;
   int            grew_count = 0;
   longint        cycle = 0;
   bit            stim_done = 0;

   // Predictor state.
   logic signed [63:0] pc[3];
   logic [63:0]        prad;
   logic signed [63:0] bc[3];
   logic [63:0]        brad;
   logic               bvalid;

   function automatic logic [63:0] isqrt128(logic [127:0] n);
      logic [63:0]  r;
      logic [127:0] c;
      r = 0;
      for (int b = 55; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if (c * c <= n) r = c;
      end
      return r;
   endfunction

   function automatic logic signed [63:0] clamp_coord(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic enclosure_type grow_sphere(sphere_type s);
      enclosure_type      o;
      logic signed [63:0] sv[3], d[3];
      logic [63:0]        a[3], span, e, nr, r;
      logic [127:0]       sum, q;
      logic               g;
      g = 0;
      r = {33'd0, s.rad};
      sv[0] = s.cx; sv[1] = s.cy; sv[2] = s.cz;
      if (s.clr) begin
         bc[0] = 0; bc[1] = 0; bc[2] = 0;
         brad = 64'hFFFFFFFF;
         bvalid = 0;
      end
      if (s.first) begin
         for (int i = 0; i < 3; i++) pc[i] = sv[i];
         prad = r;
      end else begin
         sum = 0;
         for (int i = 0; i < 3; i++) begin
            d[i] = sv[i] - pc[i];
            a[i] = d[i] < 0 ? -d[i] : d[i];
            sum = sum + {64'd0, a[i]} * {64'd0, a[i]};
         end
         span = isqrt128(sum);
         if (span + r > prad) begin
            e = span + r - prad;
            g = 1;
            if (span == 0) prad = r;
            else begin
               for (int i = 0; i < 3; i++) begin
                  q = ({64'd0, a[i]} * {64'd0, e}) / {63'd0, span, 1'b0};
                  pc[i] = clamp_coord(d[i] < 0 ? pc[i] - $signed(q[63:0])
                                               : pc[i] + $signed(q[63:0]));
               end
               nr = prad + (e >> 1) + e[0];
               prad = nr > 64'h7FFFFFFF ? 64'h7FFFFFFF : nr;
            end
         end
      end
      if (s.last && prad < brad) begin
         for (int i = 0; i < 3; i++) bc[i] = pc[i];
         brad = prad;
         bvalid = 1;
      end
      o.pcx = pc[0][bsg_pkg::CW-1:0];
      o.pcy = pc[1][bsg_pkg::CW-1:0];
      o.pcz = pc[2][bsg_pkg::CW-1:0];
      o.prad = prad[bsg_pkg::RW-1:0];
      o.bcx = bc[0][bsg_pkg::CW-1:0];
      o.bcy = bc[1][bsg_pkg::CW-1:0];
      o.bcz = bc[2][bsg_pkg::CW-1:0];
      o.brad = brad[bsg_pkg::RW-1:0];
      o.bvalid = bvalid;
      o.grew = g;
      return o;
   endfunction

   function automatic int gap_length();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 300);
   endfunction

   function automatic logic [31:0] rand_coord(int kind);
      case (kind)
         0: return $urandom_range(0, 2000) - 1000;
         1: return $urandom_range(0, 32'h00FFFFFF) - 32'h007FFFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic add_sphere(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [30:0] r, logic f, logic l, logic c);
      sphere_type s;
      s.cx = x; s.cy = y; s.cz = z; s.rad = r;
      s.first = f; s.last = l; s.clr = c;
      pending_spheres = {pending_spheres, s};
   endtask

   // Driver.
   int  send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            accepted++;
            send_gap = gap_length();
         end
         if (req_valid && req_stall) begin
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 0;
         end else if (pending_spheres.size() > 0) begin
            sphere_type s;
            s = pending_spheres.pop_front();
            expected_spheres = {expected_spheres, grow_sphere(s)};
            req_center_x <= s.cx;
            req_center_y <= s.cy;
            req_center_z <= s.cz;
            req_radius <= s.rad;
            req_first_of_pass <= s.first;
            req_last_of_pass <= s.last;
            req_start_set <= s.clr;
            req_valid <= 1;
         end else begin
            req_valid <= 0;
         end
      end
   end

   // Monitor and checker.
   int stall_left = 0;
   always @(posedge clock) begin
      cycle++;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            enclosure_type x;
            answered++;
            if (expected_spheres.size() == 0) begin
               $display("%0t: unexpected word, nothing expected", $time);
               errors++;
            end else begin
               x = expected_spheres.pop_front();
               if (x.grew) grew_count++;
               if ({rsp_pass_center_x, rsp_pass_center_y, rsp_pass_center_z,
                    rsp_pass_radius, rsp_best_center_x, rsp_best_center_y,
                    rsp_best_center_z, rsp_best_radius, rsp_best_valid, rsp_grew} !==
                   {x.pcx, x.pcy, x.pcz, x.prad, x.bcx, x.bcy, x.bcz, x.brad,
                    x.bvalid, x.grew}) begin
                  errors++;
                  $display("%0t: mismatch expected pass %0d %0d %0d r%0d best %0d %0d %0d r%0d v%0b g%0b",
                           $time, x.pcx, x.pcy, x.pcz, x.prad, x.bcx, x.bcy, x.bcz,
                           x.brad, x.bvalid, x.grew);
                  $display("%0t:          actual   pass %0d %0d %0d r%0d best %0d %0d %0d r%0d v%0b g%0b",
                           $time, rsp_pass_center_x, rsp_pass_center_y,
                           rsp_pass_center_z, rsp_pass_radius, rsp_best_center_x,
                           rsp_best_center_y, rsp_best_center_z, rsp_best_radius,
                           rsp_best_valid, rsp_grew);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1;
         end else if ($urandom_range(0, 9) < 3) begin
            stall_left = gap_length();
            rsp_stall <= stall_left > 0;
         end else begin
            rsp_stall <= 0;
         end
      end
      if (cycle > 10000000) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      int  kind, len;
      bit  clr;
      pc[0] = 0; pc[1] = 0; pc[2] = 0; prad = 0;
      bc[0] = 0; bc[1] = 0; bc[2] = 0; brad = 64'hFFFFFFFF; bvalid = 0;
      // A sphere with no seeded pass grows from the reset state.
      add_sphere(100, 0, 0, 5, 0, 0, 0);
      add_sphere(0, 0, 0, 10, 1, 0, 1);
      add_sphere(0, 0, 0, 20, 0, 0, 0);
      add_sphere(1, 1, 1, 1, 0, 0, 0);
      add_sphere(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF, 0, 1, 0);
      add_sphere(32'h80000000, 32'h80000000, 32'h80000000, 31'h7FFFFFFF, 0, 0, 0);
      add_sphere(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0, 1, 1, 0);
      add_sphere(5, 5, 5, 3, 1, 1, 1);
      add_sphere(1000, -1000, 7, 50, 1, 0, 0);
      add_sphere(-3000, 2000, 9, 70, 0, 0, 0);
      add_sphere(0, 0, 0, 1, 0, 1, 0);
      add_sphere(32'h80000000, 0, 32'h7FFFFFFF, 31'h40000000, 0, 1, 1);
      add_sphere(32'h55555555, 32'hAAAAAAAA, 32'h33333333, 31'h2AAAAAAA, 1, 0, 0);
      add_sphere(32'hAAAAAAAA, 32'h55555555, 32'hCCCCCCCC, 31'h55555555, 0, 1, 0);
      add_sphere(0, 0, 0, 0, 1, 1, 0);
      while (pending_spheres.size() < 1865) begin
         kind = $urandom_range(0, 9) < 6 ? 0 : ($urandom_range(0, 2) < 2 ? 1 : 2);
         len = $urandom_range(1, 8);
         clr = $urandom_range(0, 9) == 0;
         for (int i = 0; i < len; i++) begin
            logic [30:0] r;
            r = kind == 2 ? $urandom : (kind == 1 ? $urandom_range(0, 32'h003FFFFF)
                                                  : $urandom_range(0, 600));
            add_sphere(rand_coord(kind), rand_coord(kind), rand_coord(kind), r,
                       i == 0 ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 29) == 0),
                       i == len - 1 ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 29) == 0),
                       i == 0 ? clr : ($urandom_range(0, 49) == 0));
         end
      end
      repeat (2) @(posedge clock);
      reset <= 0;
      wait (pending_spheres.size() == 0 && !req_valid);
      wait (expected_spheres.size() == 0);
      repeat (400) @(posedge clock);
      $display("Run covered %0d spheres sent and %0d words checked; %0d spheres grew the pass.",
               accepted, answered, grew_count);
      if (errors == 0 && expected_spheres.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end
endmodule
